// ===== rtl/rhl_pkg.sv =====
package rhl_pkg;

    localparam int HISTORY_DEPTH_DEF = 5;
    localparam int PAGE_W            = 32;
    localparam int ENTRY_COUNT_W     = 3;

    localparam logic OP_VISIT = 1'b0;
    localparam logic OP_LIST  = 1'b1;

    typedef struct packed {
        logic                     opcode;
        logic signed [PAGE_W-1:0] page;
    } cmd_item_t;

    typedef struct packed {
        logic                     was_hit;
        logic                     evicted_valid;
        logic signed [PAGE_W-1:0] evicted_page;
        logic [ENTRY_COUNT_W-1:0] entry_count;
        logic                     entry_valid;
        logic signed [PAGE_W-1:0] entry_page;
        logic                     is_last;
    } res_item_t;

    typedef struct packed {
        logic              visit;
        logic              rotate;
        logic              full;
        logic [PAGE_W-1:0] key;
        logic [PAGE_W-1:0] load_data;
    } cell_ctrl_t;

endpackage

// ===== rtl/rhl_cell.sv =====
module rhl_cell #(
    parameter int HISTORY_DEPTH = rhl_pkg::HISTORY_DEPTH_DEF,
    parameter int IDX           = 0,
    parameter int CW            = $clog2(HISTORY_DEPTH + 1)
) (
    input  logic                        clk,
    input  rhl_pkg::cell_ctrl_t         ctrl,
    input  logic [CW-1:0]               count,
    input  logic                        hit,
    input  logic                        seen_in,
    output logic                        seen_out,
    input  logic [rhl_pkg::PAGE_W-1:0]  right_page,
    output logic [rhl_pkg::PAGE_W-1:0]  page
);

    logic [rhl_pkg::PAGE_W-1:0] page_reg;
    logic [rhl_pkg::PAGE_W-1:0] page_next;
    logic                       occupied;
    logic                       match;
    logic                       has_right;
    logic                       is_tail;
    logic                       is_append;
    logic                       shift_en;
    logic                       load_en;

    assign occupied  = CW'(IDX) < count;
    assign has_right = CW'(IDX + 1) < count;
    assign is_tail   = CW'(IDX + 1) == count;
    assign is_append = CW'(IDX) == count;
    assign match     = ctrl.visit && occupied && (page_reg == ctrl.key);
    assign seen_out  = seen_in || match;

    always_comb
    begin
        shift_en = has_right && (ctrl.rotate || (ctrl.visit && (hit ? seen_out : ctrl.full)));
        if (ctrl.rotate)
        begin
            load_en = is_tail;
        end
        else if (ctrl.visit)
        begin
            load_en = (hit || ctrl.full) ? is_tail : is_append;
        end
        else
        begin
            load_en = 1'b0;
        end
        if (shift_en)
        begin
            page_next = right_page;
        end
        else if (load_en)
        begin
            page_next = ctrl.load_data;
        end
        else
        begin
            page_next = page_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

    assign page = page_reg;

endmodule

// ===== rtl/recency_history_list.sv =====
// Visit item: one result, registered, ready in the cycle after acceptance; one item per cycle
// while results are taken. List item: the walk state is entered on acceptance, then each
// rotation of the cell chain registers one result, one per cycle while results are taken,
// count results in all; no new item is taken until the walk is over. An empty list gives one
// result, registered like a visit's. Reset (rst_n low, asynchronous) empties the list and
// clears the handshake state; page cells are not cleared.
module recency_history_list #(
    parameter int HISTORY_DEPTH = rhl_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  rhl_pkg::cmd_item_t  cmd,
    output logic                res_valid,
    input  logic                res_ready,
    output rhl_pkg::res_item_t  res
);

    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LIST = 1'b1;

    logic                       state_reg, state_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [CW-1:0]              idx_reg, idx_next;
    logic                       res_valid_reg, res_valid_next;
    rhl_pkg::res_item_t         res_reg, res_next;

    rhl_pkg::cell_ctrl_t        ctrl;
    logic [HISTORY_DEPTH:0]     seen;
    logic [rhl_pkg::PAGE_W-1:0] cell_page [HISTORY_DEPTH];
    logic [rhl_pkg::PAGE_W-1:0] right_page [HISTORY_DEPTH];
    logic                       hit;
    logic                       slot_free;
    logic                       accept;
    logic                       visit;
    logic                       list_start;
    logic                       rotate;
    logic                       full;
    logic                       list_last;

    assign slot_free  = !res_valid_reg || res_ready;
    assign cmd_ready  = (state_reg == ST_IDLE) && slot_free;
    assign accept     = cmd_valid && cmd_ready;
    assign visit      = accept && (cmd.opcode == rhl_pkg::OP_VISIT);
    assign list_start = accept && (cmd.opcode == rhl_pkg::OP_LIST);
    assign rotate     = (state_reg == ST_LIST) && slot_free;
    assign full       = count_reg == CW'(HISTORY_DEPTH);
    assign list_last  = (idx_reg + CW'(1)) == count_reg;
    assign hit        = seen[HISTORY_DEPTH];

    always_comb
    begin
        ctrl.visit     = visit;
        ctrl.rotate    = rotate;
        ctrl.full      = full;
        ctrl.key       = cmd.page;
        ctrl.load_data = rotate ? cell_page[0] : cmd.page;
    end

    assign seen[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < HISTORY_DEPTH; gi++)
        begin : g_cell
            if (gi + 1 < HISTORY_DEPTH)
            begin : g_right
                assign right_page[gi] = cell_page[gi + 1];
            end
            else
            begin : g_end
                assign right_page[gi] = '0;
            end

            rhl_cell #(
                .HISTORY_DEPTH (HISTORY_DEPTH),
                .IDX           (gi),
                .CW            (CW)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .count      (count_reg),
                .hit        (hit),
                .seen_in    (seen[gi]),
                .seen_out   (seen[gi + 1]),
                .right_page (right_page[gi]),
                .page       (cell_page[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_ready;

        if (visit)
        begin
            if (!hit && !full)
            begin
                count_next = count_reg + CW'(1);
            end
            res_next.was_hit       = hit;
            res_next.evicted_valid = !hit && full;
            res_next.evicted_page  = (!hit && full) ? cell_page[0] : '0;
            res_next.entry_count   = rhl_pkg::ENTRY_COUNT_W'(count_next);
            res_next.entry_valid   = 1'b0;
            res_next.entry_page    = '0;
            res_next.is_last       = 1'b1;
            res_valid_next         = 1'b1;
        end
        else if (list_start)
        begin
            if (count_reg == '0)
            begin
                res_next       = '0;
                res_next.is_last = 1'b1;
                res_valid_next = 1'b1;
            end
            else
            begin
                state_next = ST_LIST;
                idx_next   = '0;
            end
        end
        else if (rotate)
        begin
            res_next.was_hit       = 1'b0;
            res_next.evicted_valid = 1'b0;
            res_next.evicted_page  = '0;
            res_next.entry_count   = rhl_pkg::ENTRY_COUNT_W'(count_reg);
            res_next.entry_valid   = 1'b1;
            res_next.entry_page    = cell_page[0];
            res_next.is_last       = list_last;
            res_valid_next         = 1'b1;
            idx_next               = idx_reg + CW'(1);
            if (list_last)
            begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LIST) |-> (count_reg != '0) && !cmd_ready)
        else $error("list walk with empty history");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(HISTORY_DEPTH))
        else $error("history count above depth");

    a_hit_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (visit && hit) |=> $stable(count_reg))
        else $error("hit changed history count");

    a_list_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LIST) |-> (idx_reg < count_reg))
        else $error("list index past count");

endmodule

// ===== bench/recency_history_list_tb.sv =====
`timescale 1ns / 100ps

module recency_history_list_tb;

    localparam int DEPTH        = rhl_pkg::HISTORY_DEPTH_DEF;
    localparam int DRAIN_CYCLES = 8;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cmd_valid;
    logic               cmd_ready;
    rhl_pkg::cmd_item_t cmd;
    logic               res_valid;
    logic               res_ready;
    rhl_pkg::res_item_t res;

    recency_history_list #(
        .HISTORY_DEPTH(DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd      (cmd),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    logic signed [rhl_pkg::PAGE_W-1:0] hist_pages [DEPTH];
    int                                hist_count;
    rhl_pkg::res_item_t                history_reply_q [$];
    rhl_pkg::res_item_t                want_res;
    logic signed [rhl_pkg::PAGE_W-1:0] page_pool [8];

    bit calm;
    int fail_count;
    int visit_count;
    int list_count;
    int hit_count;
    int evict_count;
    int reply_count;

    function automatic void step_history(input rhl_pkg::cmd_item_t c);
        rhl_pkg::res_item_t r;
        int                 hit_at;
        begin
            r = '0;
            if (c.opcode == rhl_pkg::OP_VISIT)
            begin
                visit_count++;
                hit_at = -1;
                for (int i = 0; i < hist_count; i++)
                    if (hit_at < 0 && hist_pages[i] == c.page)
                        hit_at = i;
                if (hit_at >= 0)
                begin
                    hit_count++;
                    r.was_hit = 1'b1;
                    for (int i = hit_at; i < hist_count - 1; i++)
                        hist_pages[i] = hist_pages[i + 1];
                    hist_pages[hist_count - 1] = c.page;
                end
                else if (hist_count < DEPTH)
                begin
                    hist_pages[hist_count] = c.page;
                    hist_count++;
                end
                else
                begin
                    evict_count++;
                    r.evicted_valid = 1'b1;
                    r.evicted_page  = hist_pages[0];
                    for (int i = 0; i < DEPTH - 1; i++)
                        hist_pages[i] = hist_pages[i + 1];
                    hist_pages[DEPTH - 1] = c.page;
                end
                r.entry_count = hist_count[rhl_pkg::ENTRY_COUNT_W-1:0];
                r.is_last     = 1'b1;
                history_reply_q.push_back(r);
            end
            else
            begin
                list_count++;
                if (hist_count == 0)
                begin
                    r.is_last = 1'b1;
                    history_reply_q.push_back(r);
                end
                else
                begin
                    for (int i = 0; i < hist_count; i++)
                    begin
                        r             = '0;
                        r.entry_count = hist_count[rhl_pkg::ENTRY_COUNT_W-1:0];
                        r.entry_valid = 1'b1;
                        r.entry_page  = hist_pages[i];
                        r.is_last     = (i == hist_count - 1);
                        history_reply_q.push_back(r);
                    end
                end
            end
        end
    endfunction

    task automatic check_field(input string name, input logic [rhl_pkg::PAGE_W-1:0] want,
                               input logic [rhl_pkg::PAGE_W-1:0] got);
        begin
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready)
                step_history(cmd);
            if (res_valid && res_ready)
            begin
                if (history_reply_q.size() == 0)
                begin
                    $error("result item with nothing expected: %0h", res);
                    fail_count++;
                end
                else
                begin
                    want_res = history_reply_q.pop_front();
                    reply_count++;
                    check_field("was_hit", rhl_pkg::PAGE_W'(want_res.was_hit),
                                rhl_pkg::PAGE_W'(res.was_hit));
                    check_field("evicted_valid", rhl_pkg::PAGE_W'(want_res.evicted_valid),
                                rhl_pkg::PAGE_W'(res.evicted_valid));
                    check_field("evicted_page", want_res.evicted_page, res.evicted_page);
                    check_field("entry_count", rhl_pkg::PAGE_W'(want_res.entry_count),
                                rhl_pkg::PAGE_W'(res.entry_count));
                    check_field("entry_valid", rhl_pkg::PAGE_W'(want_res.entry_valid),
                                rhl_pkg::PAGE_W'(res.entry_valid));
                    check_field("entry_page", want_res.entry_page, res.entry_page);
                    check_field("is_last", rhl_pkg::PAGE_W'(want_res.is_last),
                                rhl_pkg::PAGE_W'(res.is_last));
                end
            end
        end
    end

    initial
    begin
        res_ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 4) == 0)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            res_ready <= 1'b1;
        end
    end

    task automatic send_cmd(input logic op, input logic signed [rhl_pkg::PAGE_W-1:0] pg);
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                cmd_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            cmd_valid  <= 1'b1;
            cmd.opcode <= op;
            cmd.page   <= pg;
            @(posedge clk);
            while (!cmd_ready)
                @(posedge clk);
        end
    endtask

    task automatic drain_history();
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
            while (history_reply_q.size() != 0)
                @(negedge clk);
            @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    task automatic test_empty_list();
        begin
            send_cmd(rhl_pkg::OP_LIST, $urandom);
            send_cmd(rhl_pkg::OP_LIST, $urandom);
            drain_history();
        end
    endtask

    task automatic test_fill_extremes();
        begin
            send_cmd(rhl_pkg::OP_VISIT, 32'sh8000_0000);
            send_cmd(rhl_pkg::OP_LIST, $urandom);
            send_cmd(rhl_pkg::OP_VISIT, 32'sh7FFF_FFFF);
            send_cmd(rhl_pkg::OP_VISIT, 32'sh0000_0000);
            send_cmd(rhl_pkg::OP_VISIT, 32'shFFFF_FFFF);
            send_cmd(rhl_pkg::OP_VISIT, 32'sh0000_0001);
            send_cmd(rhl_pkg::OP_LIST, $urandom);
            drain_history();
        end
    endtask

    task automatic test_hits();
        begin
            // inner, newest, then oldest entry
            send_cmd(rhl_pkg::OP_VISIT, 32'shFFFF_FFFF);
            send_cmd(rhl_pkg::OP_VISIT, 32'shFFFF_FFFF);
            send_cmd(rhl_pkg::OP_VISIT, 32'sh8000_0000);
            send_cmd(rhl_pkg::OP_LIST, $urandom);
            drain_history();
        end
    endtask

    task automatic test_evictions();
        begin
            send_cmd(rhl_pkg::OP_VISIT, 32'sh0000_002A);
            send_cmd(rhl_pkg::OP_VISIT, 32'sh7FFF_FFFF);
            send_cmd(rhl_pkg::OP_VISIT, 32'sh5555_AAAA);
            send_cmd(rhl_pkg::OP_VISIT, 32'shAAAA_5555);
            send_cmd(rhl_pkg::OP_LIST, $urandom);
            drain_history();
        end
    endtask

    task automatic test_random_traffic(input int n_items);
        logic                              op;
        logic signed [rhl_pkg::PAGE_W-1:0] pg;
        begin
            page_pool[0] = 32'sh8000_0000;
            page_pool[1] = 32'sh7FFF_FFFF;
            for (int i = 2; i < 8; i++)
                page_pool[i] = $urandom;
            for (int k = 0; k < n_items; k++)
            begin
                if ($urandom_range(0, 15) == 0)
                    page_pool[3'($urandom_range(0, 7))] = $urandom;
                op = ($urandom_range(0, 99) < 15) ? rhl_pkg::OP_LIST : rhl_pkg::OP_VISIT;
                if (op == rhl_pkg::OP_LIST || $urandom_range(0, 9) < 3)
                    pg = $urandom;
                else
                    pg = page_pool[3'($urandom_range(0, 7))];
                send_cmd(op, pg);
            end
            drain_history();
        end
    endtask

    initial
    begin
        calm        = 1'b0;
        fail_count  = 0;
        visit_count = 0;
        list_count  = 0;
        hit_count   = 0;
        evict_count = 0;
        reply_count = 0;
        hist_count  = 0;
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_fill_extremes();
        test_hits();
        test_evictions();
        test_random_traffic(262);
        calm = 1'b1;
        test_random_traffic(30);

        $display("covered %0d visits (%0d hits, %0d evictions) and %0d list requests",
                 visit_count, hit_count, evict_count, list_count);
        $display("checked %0d result items against the predicted history", reply_count);
        if (fail_count == 0)
            $display("recency_history_list regression: pass");
        else
            $display("recency_history_list regression: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("recency_history_list regression: fail");
        $finish;
    end

endmodule
